// ----- rtl/core/imufb_pkg.sv -----
`timescale 1ns / 1ps

package imufb_pkg;

  // Frame geometry
  localparam int unsigned FRAME_BYTES = 24;
  localparam int unsigned IDX_W       = 5;
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(22);
  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(23);
  localparam logic [IDX_W-1:0] FLIP_INDEX = IDX_W'(12);
  localparam logic [7:0]       FLIP_MASK  = 8'h01;

  // CRC span: bytes 2..21
  localparam logic [IDX_W-1:0] CRC_FIRST = IDX_W'(2);
  localparam logic [IDX_W-1:0] CRC_LAST_STEP = IDX_W'(19);
  localparam logic [15:0]      CRC_INIT  = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY  = 16'h1021;

  // Header bytes
  localparam logic [7:0] SYNC0     = 8'hAA;
  localparam logic [7:0] SYNC1     = 8'h55;
  localparam logic [7:0] LEN_FIELD = 8'd18;

  // Injection period register
  localparam logic [7:0] PERIOD_RESET = 8'd10;
  localparam logic [IDX_W-1:0] REM_STEPS = IDX_W'(8);

  // Descriptor queue
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef struct packed {
    logic        [31:0] timestamp_us;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] temperature;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic               corrupt_enable;
  } sample_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [7:0]  frame_seq;
    logic [31:0] injected_count;
  } result_t;

  // Everything the serializer needs to send one frame
  typedef struct packed {
    sample_t     smp;
    logic [7:0]  seq;
    logic [15:0] crc;
    logic        flip;
    logic [31:0] count;
  } frame_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Frame byte at a given index, bytes 0..21 (CRC bytes added by the serializer)
  function automatic logic [7:0] body_byte(sample_t s, logic [7:0] seq,
                                           logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      5'd0:    b = SYNC0;
      5'd1:    b = SYNC1;
      5'd2:    b = LEN_FIELD;
      5'd3:    b = seq;
      5'd4:    b = s.timestamp_us[7:0];
      5'd5:    b = s.timestamp_us[15:8];
      5'd6:    b = s.timestamp_us[23:16];
      5'd7:    b = s.timestamp_us[31:24];
      5'd8:    b = s.accel_x[15:8];
      5'd9:    b = s.accel_x[7:0];
      5'd10:   b = s.accel_y[15:8];
      5'd11:   b = s.accel_y[7:0];
      5'd12:   b = s.accel_z[15:8];
      5'd13:   b = s.accel_z[7:0];
      5'd14:   b = s.temperature[15:8];
      5'd15:   b = s.temperature[7:0];
      5'd16:   b = s.gyro_x[15:8];
      5'd17:   b = s.gyro_x[7:0];
      5'd18:   b = s.gyro_y[15:8];
      5'd19:   b = s.gyro_y[7:0];
      5'd20:   b = s.gyro_z[15:8];
      5'd21:   b = s.gyro_z[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // One byte of CRC-16/CCITT-FALSE, eight shift steps
  function automatic logic [15:0] crc_byte(logic [15:0] c_in, logic [7:0] data);
    logic [15:0] c;
    c = c_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/imufb_front.sv -----
`timescale 1ns / 1ps

module imufb_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  imufb_pkg::sample_t    sample_i,
  input  logic [7:0]            period_i,
  input  imufb_pkg::q_status_t  q_status_i,
  output logic                  q_push_o,
  output imufb_pkg::frame_desc_t q_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_PUSH = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;

  imufb_pkg::sample_t           smp_q, smp_d;
  logic [7:0]                   seq_cnt_q, seq_cnt_d;
  logic [7:0]                   seq_cur_q, seq_cur_d;
  logic [15:0]                  crc_q, crc_d;
  logic [7:0]                   rem_q, rem_d;
  logic [imufb_pkg::IDX_W-1:0]  step_q, step_d;
  logic [31:0]                  err_q, err_d;

  logic                         accept;
  logic [7:0]                   seq_next;
  logic [8:0]                   rem_shift;
  logic [imufb_pkg::IDX_W-1:0]  byte_idx;
  logic [2:0]                   bit_sel;
  logic                         inject;

  assign full     = (state_q != ST_IDLE);
  assign accept   = push && !full;
  assign seq_next = seq_cur_q + 8'd1;
  assign byte_idx = step_q + imufb_pkg::CRC_FIRST;
  assign bit_sel  = 3'(3'd7 - step_q[2:0]);
  assign rem_shift = {rem_q, seq_next[bit_sel]};
  assign inject   = smp_q.corrupt_enable && (period_i != 8'd0) && (rem_q == 8'd0);

  // Hand the finished descriptor to the queue
  assign q_push_o        = (state_q == ST_PUSH) && !q_status_i.full;
  assign q_data_o.smp    = smp_q;
  assign q_data_o.seq    = seq_cur_q;
  assign q_data_o.crc    = crc_q;
  assign q_data_o.flip   = inject;
  assign q_data_o.count  = err_q + {31'd0, inject};

  // Accept, then run CRC one byte a cycle and the period remainder one bit a cycle
  always_comb begin
    state_d   = state_q;
    smp_d     = smp_q;
    seq_cnt_d = seq_cnt_q;
    seq_cur_d = seq_cur_q;
    crc_d     = crc_q;
    rem_d     = rem_q;
    step_d    = step_q;
    err_d     = err_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          smp_d     = sample_i;
          seq_cur_d = seq_cnt_q;
          seq_cnt_d = seq_cnt_q + 8'd1;
          crc_d     = imufb_pkg::CRC_INIT;
          rem_d     = 8'd0;
          step_d    = '0;
          state_d   = ST_CALC;
        end
      end
      ST_CALC: begin
        crc_d = imufb_pkg::crc_byte(crc_q,
                  imufb_pkg::body_byte(smp_q, seq_cur_q, byte_idx));
        if (step_q < imufb_pkg::REM_STEPS) begin
          if (rem_shift >= {1'b0, period_i}) begin
            rem_d = 8'(rem_shift - {1'b0, period_i});
          end else begin
            rem_d = rem_shift[7:0];
          end
        end
        step_d = step_q + 5'd1;
        if (step_q == imufb_pkg::CRC_LAST_STEP) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_status_i.full) begin
          err_d   = err_q + {31'd0, inject};
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seq_cnt_q <= 8'd0;
      err_q     <= 32'd0;
    end else begin
      state_q   <= state_d;
      seq_cnt_q <= seq_cnt_d;
      err_q     <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q     <= smp_d;
    seq_cur_q <= seq_cur_d;
    crc_q     <= crc_d;
    rem_q     <= rem_d;
    step_q    <= step_d;
  end

endmodule

// ----- rtl/core/imufb_queue.sv -----
`timescale 1ns / 1ps

module imufb_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  imufb_pkg::frame_desc_t data_i,
  input  logic                   pop_i,
  output imufb_pkg::frame_desc_t data_o,
  output imufb_pkg::q_status_t   status_o
);

  imufb_pkg::frame_desc_t mem_q [imufb_pkg::QDEPTH];
  logic [imufb_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [imufb_pkg::QCNT_W-1:0] cnt_q;

  logic do_push, do_pop;

  assign status_o.full  = (cnt_q == imufb_pkg::QCNT_W'(imufb_pkg::QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rptr_q];

  // Store incoming descriptors
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/imufb_back.sv -----
`timescale 1ns / 1ps

module imufb_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  imufb_pkg::frame_desc_t desc_i,
  input  imufb_pkg::q_status_t   q_status_i,
  output logic                   q_pop_o,
  output logic                   empty,
  input  logic                   pop,
  output imufb_pkg::result_t     result_o
);

  imufb_pkg::result_t           out_q, out_d;
  logic                         out_vld_q, out_vld_d;
  logic [imufb_pkg::IDX_W-1:0]  idx_q, idx_d;

  logic                         load;
  logic [7:0]                   raw_byte;
  logic [7:0]                   tx_byte;

  assign empty    = !out_vld_q;
  assign result_o = out_q;
  assign load     = (!out_vld_q || pop) && !q_status_i.empty;
  assign q_pop_o  = load && (idx_q == imufb_pkg::IDX_LAST);

  // Pick the byte for the current index, CRC at the tail, flip after CRC
  always_comb begin
    if (idx_q == imufb_pkg::IDX_CRC_HI) begin
      raw_byte = desc_i.crc[15:8];
    end else if (idx_q == imufb_pkg::IDX_CRC_LO) begin
      raw_byte = desc_i.crc[7:0];
    end else begin
      raw_byte = imufb_pkg::body_byte(desc_i.smp, desc_i.seq, idx_q);
    end
    tx_byte = raw_byte;
    if (desc_i.flip && (idx_q == imufb_pkg::FLIP_INDEX)) begin
      tx_byte = raw_byte ^ imufb_pkg::FLIP_MASK;
    end
  end

  // Load the output register one beat a cycle while the consumer keeps up and a descriptor is queued
  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q;
    idx_d     = idx_q;
    if (load) begin
      out_d.frame_byte     = tx_byte;
      out_d.last_byte      = (idx_q == imufb_pkg::IDX_LAST);
      out_d.frame_seq      = desc_i.seq;
      out_d.injected_count = desc_i.count;
      out_vld_d            = 1'b1;
      idx_d = (idx_q == imufb_pkg::IDX_LAST) ? '0 : idx_q + 5'd1;
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // A frame in progress keeps its descriptor at the head of the queue
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> !q_status_i.empty)
    else $error("frame in progress without a queued descriptor");

  // The final byte of a frame is the beat that releases the descriptor
  a_last_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (out_vld_q && out_q.last_byte))
    else $error("descriptor released without a last byte");

  // Never release a descriptor mid-frame
  a_pop_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (idx_q == imufb_pkg::IDX_LAST))
    else $error("descriptor released before the last byte");

endmodule

// ----- rtl/core/imu_frame_builder_crc16_core.sv -----
`timescale 1ns / 1ps

// IMU frame builder: each accepted sample becomes a 24-byte frame (sync AA 55,
// length 18, sequence, little-endian timestamp, seven big-endian 16-bit
// readings, big-endian CRC-16/CCITT-FALSE over bytes 2..21), delivered one
// byte per pop with last_byte set on byte 24. A frame occupies the output for
// 24 beats, one beat a cycle while every beat is popped, so the sustained rate
// is set by the byte serializer. The front end takes each sample through one
// accept step, twenty CRC byte steps and one hand-off, and works on the next
// sample while the previous frame streams out of a two-deep descriptor queue.
// With corrupt_enable set and (sequence + 1) mod inject_period equal to zero,
// bit 0 of byte 12 is flipped after the CRC and the injected-error count rises;
// a period of 0 disables injection. Write inject_period only while idle.
module imu_frame_builder_crc16_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  imufb_pkg::sample_t sample_i,
  output logic               empty,
  input  logic               pop,
  output imufb_pkg::result_t result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);

  logic [7:0]             period_q;
  logic                   q_push, q_pop;
  imufb_pkg::frame_desc_t q_wdata, q_rdata;
  imufb_pkg::q_status_t   q_status;

  // Hold the injection period
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= imufb_pkg::PERIOD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      period_q <= cfg_data_i;
    end
  end

  imufb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .sample_i   (sample_i),
    .period_i   (period_q),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  imufb_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (q_wdata),
    .pop_i    (q_pop),
    .data_o   (q_rdata),
    .status_o (q_status)
  );

  imufb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .desc_i     (q_rdata),
    .q_status_i (q_status),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

endmodule

// ----- bench/tb_imu_frame_builder_crc16_core.sv -----
`timescale 1ns / 1ps

module tb_imu_frame_builder_crc16_core;

  // Clock, reset and block ports
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 push        = 1'b0;
  logic                 full;
  imufb_pkg::sample_t   sample_i    = '0;
  logic                 empty;
  logic                 pop         = 1'b0;
  imufb_pkg::result_t   result_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [7:0]           cfg_data_i  = 8'h00;

  imu_frame_builder_crc16_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .sample_i    (sample_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Samples waiting to be sent and frame bytes waiting to come out
  imufb_pkg::sample_t sample_q[$];
  imufb_pkg::result_t frame_bytes_q[$];

  // Local copy of the block's state and register
  logic [7:0]  seq_model     = 8'h00;
  logic [31:0] err_count_model = 32'h0;
  logic [7:0]  period_model  = imufb_pkg::PERIOD_RESET;

  // Handshake bookkeeping and idle control
  logic        push_taken  = 1'b0;
  logic        pop_taken   = 1'b0;
  logic        send_steady = 1'b0;
  logic        take_steady = 1'b0;
  int unsigned send_wait   = 0;
  int unsigned pop_wait    = 0;

  // Run statistics
  int unsigned mismatch_count  = 0;
  int unsigned samples_sent    = 0;
  int unsigned bytes_checked   = 0;
  int unsigned flips_predicted = 0;
  int unsigned periods_written = 0;

  // Build the 24 bytes one sample turns into and advance the state
  function automatic void build_frame(input imufb_pkg::sample_t s);
    logic [7:0]         body [0:21];
    logic [15:0]        crc;
    logic [7:0]         seq_now;
    logic [7:0]         seq_next;
    logic [15:0]        words [0:6];
    imufb_pkg::result_t beat;
    seq_now  = seq_model;
    seq_next = seq_model + 8'd1;
    seq_model = seq_next;
    words[0] = s.accel_x;
    words[1] = s.accel_y;
    words[2] = s.accel_z;
    words[3] = s.temperature;
    words[4] = s.gyro_x;
    words[5] = s.gyro_y;
    words[6] = s.gyro_z;
    body[0] = imufb_pkg::SYNC0;
    body[1] = imufb_pkg::SYNC1;
    body[2] = imufb_pkg::LEN_FIELD;
    body[3] = seq_now;
    for (int i = 0; i < 4; i++) begin
      body[4 + i] = s.timestamp_us[8*i +: 8];
    end
    for (int i = 0; i < 7; i++) begin
      body[8 + 2*i] = words[i][15:8];
      body[9 + 2*i] = words[i][7:0];
    end
    // CRC over length through last reading, MSB first
    crc = imufb_pkg::CRC_INIT;
    for (int i = 2; i < 22; i++) begin
      crc = crc ^ {body[i], 8'h00};
      for (int b = 0; b < 8; b++) begin
        crc = crc[15] ? ({crc[14:0], 1'b0} ^ imufb_pkg::CRC_POLY)
                      : {crc[14:0], 1'b0};
      end
    end
    // Deliberate error lands after the CRC, so the CRC no longer matches
    if (s.corrupt_enable && period_model != 8'd0 && (seq_next % period_model) == 8'd0) begin
      body[12] = body[12] ^ imufb_pkg::FLIP_MASK;
      err_count_model = err_count_model + 32'd1;
      flips_predicted++;
    end
    for (int i = 0; i < imufb_pkg::FRAME_BYTES; i++) begin
      beat.frame_byte     = (i < 22) ? body[i] : ((i == 22) ? crc[15:8] : crc[7:0]);
      beat.last_byte      = (i == imufb_pkg::FRAME_BYTES - 1);
      beat.frame_seq      = seq_now;
      beat.injected_count = err_count_model;
      frame_bytes_q.push_back(beat);
    end
  endfunction

  // Check output beats, then record accepted samples
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (frame_bytes_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected byte %02h seq %02h", $realtime,
                     result_o.frame_byte, result_o.frame_seq);
          end
        end else begin
          if (result_o !== frame_bytes_q[0]) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: byte exp %02h got %02h, last exp %0b got %0b", $realtime,
                       frame_bytes_q[0].frame_byte, result_o.frame_byte,
                       frame_bytes_q[0].last_byte, result_o.last_byte);
              $display("    seq exp %02h got %02h, count exp %08h got %08h",
                       frame_bytes_q[0].frame_seq, result_o.frame_seq,
                       frame_bytes_q[0].injected_count, result_o.injected_count);
            end
          end
          void'(frame_bytes_q.pop_front());
          bytes_checked++;
        end
      end
      if (push && !full) begin
        build_frame(sample_i);
        samples_sent++;
      end
      push_taken <= push && !full;
      pop_taken  <= pop && !empty;
    end
  end

  // Sample sender: drop the accepted beat, wait a drawn gap, present the next
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push_taken) begin
        void'(sample_q.pop_front());
        send_wait = send_steady ? 0 : $urandom_range(0, 6);
      end
      if (send_wait != 0) begin
        send_wait--;
        push <= 1'b0;
      end else if (sample_q.size() != 0) begin
        push     <= 1'b1;
        sample_i <= sample_q[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Byte receiver: stall a drawn number of cycles after each beat
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pop_taken) begin
        pop_wait = take_steady ? 0 : $urandom_range(0, 6);
      end
      if (pop_wait != 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic imufb_pkg::sample_t flat_sample(input logic [31:0] ts,
                                                     input logic [15:0] w,
                                                     input logic corrupt);
    imufb_pkg::sample_t s;
    s.timestamp_us   = ts;
    s.accel_x        = w;
    s.accel_y        = w;
    s.accel_z        = w;
    s.temperature    = w;
    s.gyro_x         = w;
    s.gyro_y         = w;
    s.gyro_z         = w;
    s.corrupt_enable = corrupt;
    return s;
  endfunction

  // Mostly random words, with the signed extremes mixed in
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic imufb_pkg::sample_t random_sample();
    imufb_pkg::sample_t s;
    case ($urandom_range(0, 9))
      0: s.timestamp_us = 32'h0000_0000;
      1: s.timestamp_us = 32'hFFFF_FFFF;
      default: s.timestamp_us = $urandom;
    endcase
    s.accel_x        = pick_word();
    s.accel_y        = pick_word();
    s.accel_z        = pick_word();
    s.temperature    = pick_word();
    s.gyro_x         = pick_word();
    s.gyro_y         = pick_word();
    s.gyro_z         = pick_word();
    s.corrupt_enable = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Hold the stimulus until every queued frame has come out
  task automatic drain_frames();
    while (sample_q.size() != 0 || push || frame_bytes_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    period_model = value;
    periods_written++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(input logic [7:0] period, input int unsigned count);
    write_period(period);
    @(posedge clk_i);
    send_steady = ($urandom_range(0, 3) == 0);
    take_steady = ($urandom_range(0, 3) == 0);
    repeat (count) sample_q.push_back(random_sample());
    drain_frames();
  endtask

  // Stimulus
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset period: extremes of every field, injection due on the tenth frame
    @(posedge clk_i);
    send_steady = 1'b1;
    take_steady = 1'b1;
    sample_q.push_back(flat_sample(32'h0000_0000, 16'h0000, 1'b0));
    sample_q.push_back(flat_sample(32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    sample_q.push_back(flat_sample(32'h0000_0000, 16'h8000, 1'b1));
    sample_q.push_back(flat_sample(32'hFFFF_FFFF, 16'h7FFF, 1'b0));
    sample_q.push_back(flat_sample(32'h5555_AAAA, 16'h5A5A, 1'b1));
    sample_q.push_back(flat_sample(32'h0123_4567, 16'hA5A5, 1'b0));
    repeat (6) sample_q.push_back(random_sample());
    sample_q[9].corrupt_enable = 1'b1;
    sample_q[10].corrupt_enable = 1'b1;
    drain_frames();

    // Period one: every enabled frame is hit
    write_period(8'd1);
    @(posedge clk_i);
    send_steady = 1'b0;
    take_steady = 1'b0;
    for (int i = 0; i < 5; i++) begin
      sample_q.push_back(flat_sample($urandom, pick_word(), i[0] ^ 1'b1));
    end
    drain_frames();

    // Zero period: injection off even with the flag set
    write_period(8'd0);
    @(posedge clk_i);
    repeat (4) sample_q.push_back(flat_sample($urandom, pick_word(), 1'b1));
    drain_frames();

    // Random phases; the fourth one carries the sequence through its wrap
    random_phase(8'd7, 60);
    random_phase(8'd1, 60);
    random_phase(8'd0, 60);
    random_phase(8'd255, 60);
    random_phase(8'($urandom_range(2, 254)), 60);
    random_phase(imufb_pkg::PERIOD_RESET, 60);

    repeat (30) @(posedge clk_i);
    $display("covered %0d samples, %0d frame bytes, %0d injected errors",
             samples_sent, bytes_checked, flips_predicted);
    $display("period written %0d times incl. 0, 1 and 255; sequence wrapped past 255",
             periods_written);
    if (mismatch_count == 0 && frame_bytes_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d bytes never seen", mismatch_count, frame_bytes_q.size());
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("timeout with %0d bytes outstanding", frame_bytes_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
